[rtl/tcw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg - shared types and constants for the text console writer
// Field widths, blank cell contents and character codes used by the console
// sequencer and its screen memory.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // port field widths
  localparam int ACTION_W = 1;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 4;
  localparam int INDEX_W  = 11;
  localparam int ATTR_W   = 8;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_PUT  = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_READ = 1'b1;

  // character codes
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [COLOR_W-1:0] BLANK_ATTR  = 4'h7;

  // one screen cell: attributes only ever hold a 4-bit colour
  typedef struct packed {
    logic [COLOR_W-1:0] attr;
    logic [CHAR_W-1:0]  chr;
  } cell_t;

  localparam cell_t BLANK_CELL = '{attr: BLANK_ATTR, chr: BLANK_CHAR};

endpackage

[rtl/tcw_screen_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_screen_ram - screen cell memory
// One write port and one read port with registered read data; the read
// data holds while no read is enabled.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  tcw_pkg::cell_t      wdata,
  input  logic                re,
  input  logic [ADDR_W-1:0]   raddr,
  output tcw_pkg::cell_t      rdata
);

  tcw_pkg::cell_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/text_console_writer.sv]
`timescale 1ns / 1ps
// Read word: the cell is read on acceptance, the reply registered in S_RESULT; put
// word: the cell is written on acceptance, the cursor steps in S_ADVANCE, and the
// reply is registered in S_RESULT, which waits while an earlier reply is held. No
// new word is taken until then. A put or newline past the last cell scrolls the
// screen through the single write port. After reset the memory is blanked one cell
// per cycle with in_ready low; the cursor resets to cell zero.
// ----------------------------------------------------------------------------
// text_console_writer - character console with cursor and scrolling
// Writes characters at a linear cursor, handles newline, scrolls the screen
// up one row past the last cell and returns single cells on read.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tcw_pkg::ACTION_W-1:0] action,
  input  logic [tcw_pkg::CHAR_W-1:0]   character,
  input  logic [tcw_pkg::COLOR_W-1:0]  color,
  input  logic [tcw_pkg::INDEX_W-1:0]  cell_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tcw_pkg::INDEX_W-1:0]  cursor_position,
  output logic [tcw_pkg::CHAR_W-1:0]   read_char,
  output logic [tcw_pkg::ATTR_W-1:0]   read_attr
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int COPY_N = (ROWS - 1) * COLUMNS;
  localparam int CELL_W = $clog2(CELLS);
  localparam int CUR_W  = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int IDX_W  = (CUR_W > tcw_pkg::INDEX_W) ? CUR_W : tcw_pkg::INDEX_W;

  // sequencer states
  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_ADVANCE = 3'd2;
  localparam logic [2:0] S_COPY    = 3'd3;
  localparam logic [2:0] S_BLANK   = 3'd4;
  localparam logic [2:0] S_RESULT  = 3'd5;

  logic [2:0]       state;
  logic [CELL_W-1:0] k;
  logic [CELL_W-1:0] dst;
  logic             copy_wr;
  logic [CUR_W-1:0] cursor;
  logic [CUR_W-1:0] row_base;
  logic [COL_W-1:0] col;
  logic             is_read;
  logic             is_newline;
  logic             in_range;

  logic             accept;
  logic [IDX_W-1:0] idx_ext;
  logic [IDX_W-1:0] cur_ext;
  logic [CUR_W-1:0] cursor_next;
  logic [CUR_W-1:0] row_base_next;
  logic [COL_W-1:0] col_next;

  logic             we;
  logic [CELL_W-1:0] waddr;
  tcw_pkg::cell_t   wdata;
  logic             re;
  logic [CELL_W-1:0] raddr;
  tcw_pkg::cell_t   rdata;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign idx_ext  = IDX_W'(cell_index);
  assign cur_ext  = IDX_W'(cursor);

  // cursor step for a put or a newline
  always_comb begin
    if (is_newline) begin
      row_base_next = row_base + CUR_W'(COLUMNS);
      cursor_next   = row_base_next;
      col_next      = '0;
    end else if (col == COL_W'(COLUMNS - 1)) begin
      row_base_next = row_base + CUR_W'(COLUMNS);
      cursor_next   = cursor + 1'b1;
      col_next      = '0;
    end else begin
      row_base_next = row_base;
      cursor_next   = cursor + 1'b1;
      col_next      = col + 1'b1;
    end
  end

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = k;
    wdata = tcw_pkg::BLANK_CELL;
    re    = 1'b0;
    raddr = k + CELL_W'(COLUMNS);
    case (state)
      S_IDLE: begin
        if (accept && action == tcw_pkg::ACT_READ) begin
          re    = 1'b1;
          raddr = idx_ext[CELL_W-1:0];
        end else if (accept && character != tcw_pkg::NEWLINE_CODE) begin
          we    = 1'b1;
          waddr = cursor[CELL_W-1:0];
          wdata = '{attr: color, chr: character};
        end
      end
      S_COPY: begin
        we    = copy_wr;
        waddr = dst;
        wdata = rdata;
        re    = (k != CELL_W'(COPY_N));
      end
      S_BLANK, S_CLEAR: begin
        we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      k        <= '0;
      copy_wr  <= 1'b0;
      cursor   <= '0;
      row_base <= '0;
      col      <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          k <= k + 1'b1;
          if (k == CELL_W'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            is_read    <= (action == tcw_pkg::ACT_READ);
            is_newline <= (character == tcw_pkg::NEWLINE_CODE);
            in_range   <= (idx_ext < IDX_W'(CELLS));
            state      <= (action == tcw_pkg::ACT_READ) ? S_RESULT : S_ADVANCE;
          end
        end
        S_ADVANCE: begin
          if (cursor_next == CUR_W'(CELLS)) begin
            k     <= '0;
            state <= S_COPY;
          end else begin
            cursor   <= cursor_next;
            row_base <= row_base_next;
            col      <= col_next;
            state    <= S_RESULT;
          end
        end
        S_COPY: begin
          // read the row below, write it on the next cycle; the last cycle drains
          dst <= k;
          if (k == CELL_W'(COPY_N)) begin
            copy_wr <= 1'b0;
            state   <= S_BLANK;
          end else begin
            copy_wr <= 1'b1;
            k       <= k + 1'b1;
          end
        end
        S_BLANK: begin
          k <= k + 1'b1;
          if (k == CELL_W'(CELLS - 1)) begin
            cursor   <= CUR_W'(COPY_N);
            row_base <= CUR_W'(COPY_N);
            col      <= '0;
            state    <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESULT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESULT && (!out_valid || out_ready)) begin
      cursor_position <= cur_ext[tcw_pkg::INDEX_W-1:0];
      if (is_read && in_range) begin
        read_char <= rdata.chr;
        read_attr <= tcw_pkg::ATTR_W'(rdata.attr);
      end else begin
        read_char <= '0;
        read_attr <= '0;
      end
    end
  end

  tcw_screen_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (CELL_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // cursor stays on the screen between words
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (cursor < CUR_W'(CELLS)))
    else $error("cursor beyond last cell");

  // linear cursor agrees with row start and column
  a_cursor_split: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (cursor == row_base + CUR_W'(col)))
    else $error("cursor and row/column disagree");

  // a read leaves the cursor alone
  a_read_cursor: assert property (@(posedge clk) disable iff (rst)
    (accept && action == tcw_pkg::ACT_READ) |=> $stable(cursor))
    else $error("read moved the cursor");

  // no word taken while the screen is being cleared or scrolled
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR || state == S_COPY || state == S_BLANK) |-> !in_ready)
    else $error("ready during memory sweep");

endmodule

[test/text_console_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_checker - screen and cursor predictor for the console writer
// Watches both word channels, keeps its own copy of the screen store and the
// cursor, works out the reply to every accepted word and compares each reply
// leaving the block against the oldest one still due.
// ----------------------------------------------------------------------------
module text_console_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [tcw_pkg::ACTION_W-1:0] action,
  input  logic [tcw_pkg::CHAR_W-1:0]   character,
  input  logic [tcw_pkg::COLOR_W-1:0]  color,
  input  logic [tcw_pkg::INDEX_W-1:0]  cell_index,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [tcw_pkg::INDEX_W-1:0]  cursor_position,
  input  logic [tcw_pkg::CHAR_W-1:0]   read_char,
  input  logic [tcw_pkg::ATTR_W-1:0]   read_attr,
  output int                           mismatches,
  output int                           outstanding
);

  localparam int CELL_COUNT   = COLUMNS * ROWS;
  localparam int LAST_ROW     = (ROWS - 1) * COLUMNS;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [tcw_pkg::INDEX_W-1:0] cursor;
    logic [tcw_pkg::CHAR_W-1:0]  chr;
    logic [tcw_pkg::ATTR_W-1:0]  attr;
  } reply_t;

  // screen copy: attribute in the high byte, character in the low byte
  logic [tcw_pkg::ATTR_W+tcw_pkg::CHAR_W-1:0] screen_copy [CELL_COUNT];
  logic [tcw_pkg::INDEX_W-1:0]                cursor_copy;
  reply_t                                     due_replies [$];
  reply_t                                     due_reply;

  function automatic logic [tcw_pkg::ATTR_W+tcw_pkg::CHAR_W-1:0] blank_cell();
    return {tcw_pkg::ATTR_W'(tcw_pkg::BLANK_ATTR), tcw_pkg::BLANK_CHAR};
  endfunction

  function automatic void blank_screen();
    for (int i = 0; i < CELL_COUNT; i++) screen_copy[i] = blank_cell();
    cursor_copy = '0;
  endfunction

  // rows one up, bottom row blanked, cursor to the start of the bottom row
  function automatic void scroll_screen();
    for (int i = 0; i < LAST_ROW; i++) screen_copy[i] = screen_copy[i + COLUMNS];
    for (int i = LAST_ROW; i < CELL_COUNT; i++) screen_copy[i] = blank_cell();
    cursor_copy = tcw_pkg::INDEX_W'(LAST_ROW);
  endfunction

  // apply one word to the screen copy and return the reply it must produce
  function automatic reply_t console_apply(input logic [tcw_pkg::ACTION_W-1:0] act,
                                           input logic [tcw_pkg::CHAR_W-1:0]   chr,
                                           input logic [tcw_pkg::COLOR_W-1:0]  col,
                                           input logic [tcw_pkg::INDEX_W-1:0]  idx);
    reply_t r;
    r = '0;
    if (cursor_copy >= CELL_COUNT) cursor_copy = '0;
    if (act == tcw_pkg::ACT_READ) begin
      // out of range reads give zeros
      if (idx < CELL_COUNT) begin
        r.chr  = screen_copy[idx][tcw_pkg::CHAR_W-1:0];
        r.attr = screen_copy[idx][tcw_pkg::ATTR_W+tcw_pkg::CHAR_W-1:tcw_pkg::CHAR_W];
      end
    end else if (chr == tcw_pkg::NEWLINE_CODE) begin
      cursor_copy = tcw_pkg::INDEX_W'((cursor_copy / COLUMNS + 1) * COLUMNS);
      if (cursor_copy >= CELL_COUNT) scroll_screen();
    end else begin
      screen_copy[cursor_copy] = {tcw_pkg::ATTR_W'(col), chr};
      cursor_copy = cursor_copy + 1'b1;
      if (cursor_copy >= CELL_COUNT) scroll_screen();
    end
    r.cursor = cursor_copy;
    return r;
  endfunction

  // predict on input words, compare on output words
  always @(posedge clk) begin
    if (rst) begin
      blank_screen();
      due_replies.delete();
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (in_valid && in_ready)
        due_replies.push_back(console_apply(action, character, color, cell_index));
      if (out_valid && out_ready) begin
        if (due_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: reply word with none due: cursor %0d char %02h attr %02h",
                     $time, cursor_position, read_char, read_attr);
        end else begin
          due_reply = due_replies.pop_front();
          if (cursor_position !== due_reply.cursor || read_char !== due_reply.chr ||
              read_attr !== due_reply.attr) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: reply mismatch: expected cursor %0d char %02h attr %02h, %s",
                       $time, due_reply.cursor, due_reply.chr, due_reply.attr,
                       $sformatf("got cursor %0d char %02h attr %02h",
                                 cursor_position, read_char, read_attr));
          end
        end
      end
      outstanding = due_replies.size();
    end
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench for the text console writer
// Drives put and read words through the block: a short directed opening,
// then runs of text lines, blank lines, cell reads and noise under several
// idling patterns, with one long receiver hold-off. A checker beside the
// block predicts every reply; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int CELL_COUNT   = COLUMNS * ROWS;
  localparam int PHASE_WORDS  = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 40;

  typedef enum int {
    PH_DIRECTED,
    PH_STEADY,
    PH_SEND_GAPS,
    PH_SINK_STALLS,
    PH_BOTH
  } phase_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  logic [tcw_pkg::ACTION_W-1:0] action;
  logic [tcw_pkg::CHAR_W-1:0]   character;
  logic [tcw_pkg::COLOR_W-1:0]  color;
  logic [tcw_pkg::INDEX_W-1:0]  cell_index;
  logic                         out_valid;
  logic                         out_ready;
  logic [tcw_pkg::INDEX_W-1:0]  cursor_position;
  logic [tcw_pkg::CHAR_W-1:0]   read_char;
  logic [tcw_pkg::ATTR_W-1:0]   read_attr;

  int     mismatches;
  int     outstanding;
  int     words_sent    = 0;
  int     quiet_cycles  = 0;
  int     send_gap_pct  = 0;
  int     sink_stall_pct = 0;
  phase_t phase         = PH_DIRECTED;

  always #2 clk = ~clk;

  text_console_writer #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .action          (action),
    .character       (character),
    .color           (color),
    .cell_index      (cell_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cursor_position (cursor_position),
    .read_char       (read_char),
    .read_attr       (read_attr)
  );

  text_console_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) i_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .action          (action),
    .character       (character),
    .color           (color),
    .cell_index      (cell_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cursor_position (cursor_position),
    .read_char       (read_char),
    .read_attr       (read_attr),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  // offer one word, with random gaps first, and hold it until taken
  task automatic send_word(input logic [tcw_pkg::ACTION_W-1:0] act,
                           input logic [tcw_pkg::CHAR_W-1:0]   chr,
                           input logic [tcw_pkg::COLOR_W-1:0]  col,
                           input logic [tcw_pkg::INDEX_W-1:0]  idx);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    character  <= chr;
    color      <= col;
    cell_index <= idx;
    do @(posedge clk); while (in_ready !== 1'b1);
    words_sent++;
  endtask

  task automatic put_char(input logic [tcw_pkg::CHAR_W-1:0]  chr,
                          input logic [tcw_pkg::COLOR_W-1:0] col);
    send_word(tcw_pkg::ACT_PUT, chr, col, tcw_pkg::INDEX_W'($urandom_range(2047)));
  endtask

  task automatic read_cell(input logic [tcw_pkg::INDEX_W-1:0] idx);
    send_word(tcw_pkg::ACT_READ, tcw_pkg::CHAR_W'($urandom_range(255)),
              tcw_pkg::COLOR_W'($urandom_range(15)), idx);
  endtask

  // reads lean on the bottom rows, where writing and scrolling happen
  function automatic logic [tcw_pkg::INDEX_W-1:0] pick_cell();
    int r;
    r = $urandom_range(99);
    if (r < 50)
      return tcw_pkg::INDEX_W'($urandom_range(CELL_COUNT - 1, CELL_COUNT - 2 * COLUMNS));
    if (r < 80) return tcw_pkg::INDEX_W'($urandom_range(CELL_COUNT - 1));
    return tcw_pkg::INDEX_W'($urandom_range(2047));
  endfunction

  // one random chunk: a text line, blank lines, reads or a noise word
  task automatic random_chunk();
    int kind;
    int len;
    logic [tcw_pkg::CHAR_W-1:0] c;
    kind = $urandom_range(99);
    if (kind < 45) begin
      len = ($urandom_range(5) == 0) ? $urandom_range(120, 60) : $urandom_range(30);
      repeat (len) begin
        c = tcw_pkg::CHAR_W'($urandom_range(255));
        if (c == tcw_pkg::NEWLINE_CODE) c = ~c;
        put_char(c, tcw_pkg::COLOR_W'($urandom_range(15)));
      end
      if ($urandom_range(9) < 8)
        put_char(tcw_pkg::NEWLINE_CODE, tcw_pkg::COLOR_W'($urandom_range(15)));
    end else if (kind < 60) begin
      repeat ($urandom_range(6, 1))
        put_char(tcw_pkg::NEWLINE_CODE, tcw_pkg::COLOR_W'($urandom_range(15)));
    end else if (kind < 85) begin
      repeat ($urandom_range(4, 1)) read_cell(pick_cell());
    end else begin
      send_word(tcw_pkg::ACTION_W'($urandom_range(1)), tcw_pkg::CHAR_W'($urandom_range(255)),
                tcw_pkg::COLOR_W'($urandom_range(15)),
                tcw_pkg::INDEX_W'($urandom_range(2047)));
    end
  endtask

  // receiver: random stalls, plus one long hold-off to back the block up
  initial begin : sink
    bit held_off;
    held_off = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (phase == PH_STEADY && !held_off) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int target;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    action     <= tcw_pkg::ACT_PUT;
    character  <= '0;
    color      <= '0;
    cell_index <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // blank screen after reset, range edges and ignored fields
    read_cell(tcw_pkg::INDEX_W'(0));
    read_cell(tcw_pkg::INDEX_W'(CELL_COUNT - 1));
    read_cell(tcw_pkg::INDEX_W'(CELL_COUNT));
    send_word(tcw_pkg::ACT_READ, 8'hFF, 4'hF, 11'h7FF);
    send_word(tcw_pkg::ACT_PUT, 8'h00, 4'h0, 11'h7FF);
    send_word(tcw_pkg::ACT_PUT, 8'hFF, 4'hF, 11'h000);
    // newline mid-row, then text on the next row
    put_char(tcw_pkg::NEWLINE_CODE, 4'hF);
    put_char(8'h55, 4'hA);
    put_char(8'hAA, 4'h5);
    read_cell(tcw_pkg::INDEX_W'(0));
    read_cell(tcw_pkg::INDEX_W'(1));
    read_cell(tcw_pkg::INDEX_W'(COLUMNS));
    read_cell(tcw_pkg::INDEX_W'(COLUMNS + 1));
    // newline at column zero skips a whole row untouched
    put_char(tcw_pkg::NEWLINE_CODE, 4'h0);
    put_char(tcw_pkg::NEWLINE_CODE, 4'h3);
    read_cell(tcw_pkg::INDEX_W'(2 * COLUMNS));

    for (int p = PH_STEADY; p <= PH_BOTH; p++) begin
      phase = phase_t'(p);
      case (phase)
        PH_SEND_GAPS:   begin send_gap_pct = 61; sink_stall_pct = 0;  end
        PH_SINK_STALLS: begin send_gap_pct = 0;  sink_stall_pct = 61; end
        PH_BOTH:        begin send_gap_pct = 16; sink_stall_pct = 16; end
        default:        begin send_gap_pct = 0;  sink_stall_pct = 0;  end
      endcase
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) random_chunk();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
